// ----- design/rtn_pkg.sv -----
package rtn_pkg;

   // divider operand widths
   localparam int unsigned DivNumBits = 18;
   localparam int unsigned DivDenBits = 16;
   localparam int unsigned DivCntBits = 5;

   localparam logic [17:0] MsPerMinute = 18'd60000;

   // characters of the ringtone text
   localparam logic [7:0] ChColon = 8'h3a;
   localparam logic [7:0] ChComma = 8'h2c;
   localparam logic [7:0] ChSharp = 8'h23;
   localparam logic [7:0] ChDot   = 8'h2e;
   localparam logic [7:0] ChZero  = 8'h30;
   localparam logic [7:0] ChThree = 8'h33;
   localparam logic [7:0] ChSeven = 8'h37;
   localparam logic [7:0] ChNine  = 8'h39;
   localparam logic [7:0] ChLowA  = 8'h61;
   localparam logic [7:0] ChLowB  = 8'h62;
   localparam logic [7:0] ChLowC  = 8'h63;
   localparam logic [7:0] ChLowD  = 8'h64;
   localparam logic [7:0] ChLowE  = 8'h65;
   localparam logic [7:0] ChLowF  = 8'h66;
   localparam logic [7:0] ChLowG  = 8'h67;
   localparam logic [7:0] ChLowO  = 8'h6f;

   localparam logic [7:0] DefaultLength = 8'd4;
   localparam logic [3:0] DefaultOctave = 4'd6;
   localparam logic [15:0] DefaultBpm   = 16'd63;

   // first table octave times twelve
   localparam logic [6:0] TableBase = 7'd48;
   localparam logic [6:0] TableLast = 7'd48;

   function automatic logic [3:0] letter_step(input logic [7:0] c);
      logic [3:0] s;
      case (c)
         ChLowC:  s = 4'd1;
         ChLowD:  s = 4'd3;
         ChLowE:  s = 4'd5;
         ChLowF:  s = 4'd6;
         ChLowG:  s = 4'd8;
         ChLowA:  s = 4'd10;
         ChLowB:  s = 4'd12;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

   function automatic logic [11:0] tone_of(input logic [5:0] idx);
      logic [11:0] f;
      case (idx)
         6'd1:  f = 12'd262;  6'd2:  f = 12'd277;  6'd3:  f = 12'd294;
         6'd4:  f = 12'd311;  6'd5:  f = 12'd330;  6'd6:  f = 12'd349;
         6'd7:  f = 12'd370;  6'd8:  f = 12'd392;  6'd9:  f = 12'd415;
         6'd10: f = 12'd440;  6'd11: f = 12'd466;  6'd12: f = 12'd494;
         6'd13: f = 12'd523;  6'd14: f = 12'd554;  6'd15: f = 12'd587;
         6'd16: f = 12'd622;  6'd17: f = 12'd659;  6'd18: f = 12'd698;
         6'd19: f = 12'd740;  6'd20: f = 12'd784;  6'd21: f = 12'd831;
         6'd22: f = 12'd880;  6'd23: f = 12'd932;  6'd24: f = 12'd988;
         6'd25: f = 12'd1047; 6'd26: f = 12'd1109; 6'd27: f = 12'd1175;
         6'd28: f = 12'd1245; 6'd29: f = 12'd1319; 6'd30: f = 12'd1397;
         6'd31: f = 12'd1480; 6'd32: f = 12'd1568; 6'd33: f = 12'd1661;
         6'd34: f = 12'd1760; 6'd35: f = 12'd1865; 6'd36: f = 12'd1976;
         6'd37: f = 12'd2093; 6'd38: f = 12'd2217; 6'd39: f = 12'd2349;
         6'd40: f = 12'd2489; 6'd41: f = 12'd2637; 6'd42: f = 12'd2794;
         6'd43: f = 12'd2960; 6'd44: f = 12'd3136; 6'd45: f = 12'd3322;
         6'd46: f = 12'd3520; 6'd47: f = 12'd3729; 6'd48: f = 12'd3951;
         default: f = 12'd0;
      endcase
      return f;
   endfunction

endpackage

// ----- design/rtn_channels.sv -----
interface rtn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;
   modport source(output valid, text_byte, end_of_text, input ready);
   modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

interface rtn_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] tone_hz;
   logic [18:0] length_ms;
   logic        bad_note;
   logic        last_of_run;
   modport source(output valid, tone_hz, length_ms, bad_note, last_of_run, input ready);
   modport sink(input valid, tone_hz, length_ms, bad_note, last_of_run, output ready);
endinterface

// ----- design/ringtone_text_to_notes.sv -----
// ringtone text to notes
// req_ch takes the ringtone text one byte per item, end_of_text on the last
// byte. the name is skipped up to ':', then the d=, o= and b= defaults are
// read, then the notes. rsp_ch gives zero, one or two items per text byte:
// tone in hz, length in ms, an error flag and last_of_run on the final
// item caused by that byte.
// a byte is processed one parse step per cycle. a byte that completes a
// note runs a shared bit-serial divider (whole note / duration), and the
// byte that ends the header runs it once for 60000 / bpm when bpm is not
// zero. a note byte's result is registered once the divider is done, and
// the next byte is taken only after rsp_ch has accepted its results.
// req_ch.ready is high only while no byte is in work; one byte at a time.
// while rsp_ch is stalled the result stays in the output register and the
// parser waits. reset (synchronous) returns the parser to the name field,
// with defaults 4, 6 and 63; end of text does the same after its output.
module ringtone_text_to_notes (
   input logic clock,
   input logic reset,
   rtn_req_if.sink   req_ch,
   rtn_rsp_if.source rsp_ch
);

   typedef enum logic [3:0] {
      PH_NAME, PH_HDR_D, PH_D_EQ, PH_D_NUM, PH_HDR_O, PH_O_EQ, PH_O_VAL,
      PH_O_SKIP, PH_HDR_B, PH_B_EQ, PH_B_NUM, PH_DUR, PH_LETTER, PH_SHARP,
      PH_DOT, PH_OCT
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE, S_STEP, S_WDIV, S_EDIV, S_FIN, S_OUT
   } seq_type;

   seq_type     seq_ff;
   phase_type   phase_ff;
   logic [7:0]  byte_ff;
   logic        eot_ff;
   logic        again_ff;

   logic [7:0]  dlen_ff;
   logic [3:0]  doct_ff;
   logic [15:0] bpm_ff;
   logic [17:0] whole_ff;
   logic [15:0] acc_ff;
   logic [3:0]  step_ff;
   logic        dot_ff;
   logic [3:0]  oct_ff;
   logic        pend_ff;

   // result being built
   logic        have_res_ff;
   logic [11:0] res_hz_ff;
   logic        res_bad_ff;
   logic        res_dot_ff;
   logic        res_zero_ff;
   logic [18:0] res_len_ff;

   // output register
   logic        out_valid_ff;
   logic [11:0] out_hz_ff;
   logic [18:0] out_len_ff;
   logic        out_bad_ff;
   logic        out_last_ff;

   // divider launch
   logic        div_go_ff;
   logic [17:0] div_num_ff;
   logic [15:0] div_den_ff;
   logic        div_done;
   logic [17:0] div_q;

   rtn_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go_ff),
      .dividend (div_num_ff),
      .divisor  (div_den_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // byte classes
   logic       is_digit;
   logic [3:0] digit_val;
   logic [19:0] acc_times_ten;
   logic [15:0] acc_pushed;

   assign is_digit  = (byte_ff >= rtn_pkg::ChZero) && (byte_ff <= rtn_pkg::ChNine);
   assign digit_val = 4'(byte_ff - rtn_pkg::ChZero);
   assign acc_times_ten = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                          + {16'd0, digit_val};
   assign acc_pushed = (acc_times_ten > 20'd65535) ? 16'hffff : acc_times_ten[15:0];

   // operands of the note that is emitted now
   logic [15:0] emit_den;
   logic [6:0]  tab_pos;
   logic        tab_ok;
   logic [11:0] emit_hz;
   logic        emit_bad;

   assign emit_den = (acc_ff != 16'd0) ? acc_ff : {8'd0, dlen_ff};
   // octave times twelve plus step, table starts at octave four
   assign tab_pos  = {oct_ff, 3'b000} + {1'b0, oct_ff, 2'b00} + {3'b000, step_ff};
   assign tab_ok   = (tab_pos >= rtn_pkg::TableBase)
                     && (7'(tab_pos - rtn_pkg::TableBase) <= rtn_pkg::TableLast);
   assign emit_hz  = (step_ff != 4'd0 && tab_ok)
                     ? rtn_pkg::tone_of(6'(tab_pos - rtn_pkg::TableBase)) : 12'd0;
   assign emit_bad = (bpm_ff == 16'd0) || (emit_den == 16'd0)
                     || (step_ff != 4'd0 && !tab_ok);

   // length from the divider, plus half when dotted
   logic [17:0] len_base;
   logic [18:0] len_total;
   assign len_base  = res_zero_ff ? 18'd0 : div_q;
   assign len_total = {1'b0, len_base} + (res_dot_ff ? {2'b00, len_base[17:1]} : 19'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= S_IDLE;
         phase_ff     <= PH_NAME;
         dlen_ff      <= rtn_pkg::DefaultLength;
         doct_ff      <= rtn_pkg::DefaultOctave;
         bpm_ff       <= rtn_pkg::DefaultBpm;
         whole_ff     <= '0;
         acc_ff       <= '0;
         step_ff      <= '0;
         dot_ff       <= 1'b0;
         oct_ff       <= '0;
         pend_ff      <= 1'b0;
         have_res_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         div_go_ff    <= 1'b0;
         again_ff     <= 1'b0;
      end else begin
         div_go_ff <= 1'b0;
         unique case (seq_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  byte_ff <= req_ch.text_byte;
                  eot_ff  <= req_ch.end_of_text;
                  seq_ff  <= S_STEP;
               end
            end

            // one parse step per cycle
            S_STEP: begin
               seq_ff <= S_FIN;
               unique case (phase_ff)
                  PH_NAME: if (byte_ff == rtn_pkg::ChColon) phase_ff <= PH_HDR_D;
                  PH_HDR_D: begin
                     if (byte_ff == rtn_pkg::ChLowD) phase_ff <= PH_D_EQ;
                     else begin
                        phase_ff <= PH_HDR_O;
                        seq_ff   <= S_STEP;
                     end
                  end
                  PH_D_EQ: begin
                     acc_ff   <= '0;
                     phase_ff <= PH_D_NUM;
                  end
                  PH_D_NUM: begin
                     if (is_digit) acc_ff <= acc_pushed;
                     else begin
                        if (acc_ff != 16'd0)
                           dlen_ff <= (acc_ff > 16'd255) ? 8'd255 : acc_ff[7:0];
                        acc_ff   <= '0;
                        phase_ff <= PH_HDR_O;
                     end
                  end
                  PH_HDR_O: begin
                     if (byte_ff == rtn_pkg::ChLowO) phase_ff <= PH_O_EQ;
                     else begin
                        phase_ff <= PH_HDR_B;
                        seq_ff   <= S_STEP;
                     end
                  end
                  PH_O_EQ: phase_ff <= PH_O_VAL;
                  PH_O_VAL: begin
                     if (byte_ff >= rtn_pkg::ChThree && byte_ff <= rtn_pkg::ChSeven)
                        doct_ff <= digit_val;
                     phase_ff <= PH_O_SKIP;
                  end
                  PH_O_SKIP: phase_ff <= PH_HDR_B;
                  PH_HDR_B, PH_B_NUM: begin
                     if (phase_ff == PH_HDR_B && byte_ff == rtn_pkg::ChLowB)
                        phase_ff <= PH_B_EQ;
                     else if (phase_ff == PH_B_NUM && is_digit)
                        acc_ff <= acc_pushed;
                     else begin
                        // header done: whole note time from bpm
                        logic [15:0] bpm_new;
                        bpm_new = (phase_ff == PH_B_NUM) ? acc_ff : bpm_ff;
                        bpm_ff   <= bpm_new;
                        again_ff <= (phase_ff == PH_HDR_B);
                        if (bpm_new == 16'd0) begin
                           whole_ff <= '0;
                           acc_ff   <= '0;
                           phase_ff <= PH_DUR;
                           seq_ff   <= (phase_ff == PH_HDR_B) ? S_STEP : S_FIN;
                        end else begin
                           div_go_ff  <= 1'b1;
                           div_num_ff <= rtn_pkg::MsPerMinute;
                           div_den_ff <= bpm_new;
                           seq_ff     <= S_WDIV;
                        end
                     end
                  end
                  PH_B_EQ: begin
                     acc_ff   <= '0;
                     phase_ff <= PH_B_NUM;
                  end
                  PH_DUR: begin
                     if (is_digit) acc_ff <= acc_pushed;
                     else begin
                        step_ff  <= rtn_pkg::letter_step(byte_ff);
                        dot_ff   <= 1'b0;
                        oct_ff   <= doct_ff;
                        pend_ff  <= 1'b1;
                        phase_ff <= PH_LETTER;
                     end
                  end
                  default: begin
                     if (byte_ff == rtn_pkg::ChSharp && phase_ff == PH_LETTER) begin
                        if (step_ff != 4'd0) step_ff <= step_ff + 4'd1;
                        phase_ff <= PH_SHARP;
                     end else if (byte_ff == rtn_pkg::ChDot
                                  && (phase_ff == PH_LETTER || phase_ff == PH_SHARP)) begin
                        dot_ff   <= 1'b1;
                        phase_ff <= PH_DOT;
                     end else if (is_digit && phase_ff != PH_OCT) begin
                        oct_ff   <= digit_val;
                        phase_ff <= PH_OCT;
                     end else begin
                        // note complete: launch the length division
                        res_hz_ff   <= emit_hz;
                        res_bad_ff  <= emit_bad;
                        res_dot_ff  <= dot_ff;
                        res_zero_ff <= (emit_den == 16'd0);
                        div_go_ff   <= 1'b1;
                        div_num_ff  <= whole_ff;
                        div_den_ff  <= emit_den;
                        pend_ff     <= 1'b0;
                        acc_ff      <= '0;
                        phase_ff    <= PH_DUR;
                        again_ff    <= (byte_ff != rtn_pkg::ChComma);
                        seq_ff      <= S_EDIV;
                     end
                  end
               endcase
            end

            S_WDIV: begin
               if (div_done) begin
                  whole_ff <= {div_q[15:0], 2'b00};
                  acc_ff   <= '0;
                  phase_ff <= PH_DUR;
                  seq_ff   <= again_ff ? S_STEP : S_FIN;
               end
            end

            S_EDIV: begin
               if (div_done) begin
                  res_len_ff  <= len_total;
                  have_res_ff <= 1'b1;
                  seq_ff      <= again_ff ? S_STEP : S_FIN;
               end
            end

            // deliver results, flush at end of text
            S_FIN: begin
               again_ff <= 1'b0;
               if (have_res_ff) begin
                  out_valid_ff <= 1'b1;
                  out_hz_ff    <= res_hz_ff;
                  out_len_ff   <= res_len_ff;
                  out_bad_ff   <= res_bad_ff;
                  out_last_ff  <= !(eot_ff && pend_ff);
                  have_res_ff  <= 1'b0;
                  seq_ff       <= S_OUT;
               end else if (eot_ff && pend_ff) begin
                  res_hz_ff   <= emit_hz;
                  res_bad_ff  <= emit_bad;
                  res_dot_ff  <= dot_ff;
                  res_zero_ff <= (emit_den == 16'd0);
                  div_go_ff   <= 1'b1;
                  div_num_ff  <= whole_ff;
                  div_den_ff  <= emit_den;
                  pend_ff     <= 1'b0;
                  acc_ff      <= '0;
                  seq_ff      <= S_EDIV;
               end else begin
                  if (eot_ff) begin
                     phase_ff <= PH_NAME;
                     dlen_ff  <= rtn_pkg::DefaultLength;
                     doct_ff  <= rtn_pkg::DefaultOctave;
                     bpm_ff   <= rtn_pkg::DefaultBpm;
                     whole_ff <= '0;
                     acc_ff   <= '0;
                     step_ff  <= '0;
                     dot_ff   <= 1'b0;
                     oct_ff   <= '0;
                  end
                  seq_ff <= S_IDLE;
               end
            end

            S_OUT: begin
               if (rsp_ch.ready) begin
                  out_valid_ff <= 1'b0;
                  seq_ff       <= S_FIN;
               end
            end

            default: seq_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready       = (seq_ff == S_IDLE);
   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.tone_hz     = out_hz_ff;
   assign rsp_ch.length_ms   = out_len_ff;
   assign rsp_ch.bad_note    = out_bad_ff;
   assign rsp_ch.last_of_run = out_last_ff;

   // output register is only live while waiting for the receiver
   a_out_state: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> seq_ff == S_OUT)
      else $error("result shown outside output state");

   // divider finishes only while the sequencer waits for it
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (seq_ff == S_WDIV || seq_ff == S_EDIV))
      else $error("divider result with nobody waiting");

   // no new byte while a result is still held
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !have_res_ff && !rsp_ch.valid)
      else $error("byte taken with result outstanding");

   // a result leaves only after a handshake
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.length_ms))
      else $error("stalled result dropped");

endmodule

// ----- design/rtn_divider.sv -----
module rtn_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [17:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [17:0] quotient
);

   logic [15:0] rem_ff;
   logic [17:0] quo_ff;
   logic [15:0] den_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [16:0] trial;
   logic        fits;

   // one quotient bit per cycle, restoring
   assign trial = {rem_ff, quo_ff[17]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= '0;
            quo_ff  <= dividend;
            den_ff  <= divisor;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? 16'(trial - {1'b0, den_ff}) : trial[15:0];
            quo_ff <= {quo_ff[16:0], fits};
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(rtn_pkg::DivNumBits - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
